// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl folder
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// holds on every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ouil_pkg.sv =====
// shared types and codes for the ordered unique id list
// no dependencies; used by ouil_cell and ordered_unique_id_list
package ouil_pkg;

   localparam int ID_W  = 32;
   localparam int POS_W = 8;
   localparam int CNT_W = 9;

   localparam logic [2:0] CMD_APPEND = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_REMOVE = 3'd2;
   localparam logic [2:0] CMD_MOVE   = 3'd3;
   localparam logic [2:0] CMD_LOOKUP = 3'd4;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_DUP       = 3'd1;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
   localparam logic [2:0] STAT_RANGE     = 3'd3;
   localparam logic [2:0] STAT_FULL      = 3'd4;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
      logic [ID_W-1:0]  data;
   } cell_ctl_type;

endpackage

// ===== rtl/ouil_cell.sv =====
// one list position: holds an id, compares it against the key, shifts with its neighbours
// depends on ouil_pkg
module ouil_cell
   import ouil_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic [ID_W-1:0]   key,
   input  logic [ID_W-1:0]   left_entry,
   input  logic [ID_W-1:0]   right_entry,
   output logic [ID_W-1:0]   entry,
   output logic              match
);

   localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

   logic [ID_W-1:0] entry_ff;
   logic [ID_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         CELL_SHIFT_UP: begin
            if (MY_POS == ctl.lo) begin
               entry_in = ctl.data;
            end else if (MY_POS > ctl.lo && MY_POS <= ctl.hi) begin
               entry_in = left_entry;
            end
         end
         CELL_SHIFT_DOWN: begin
            if (MY_POS == ctl.hi) begin
               entry_in = ctl.data;
            end else if (MY_POS >= ctl.lo && MY_POS < ctl.hi) begin
               entry_in = right_entry;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (entry_ff == key);

endmodule

// ===== rtl/ordered_unique_id_list.sv =====
// Ordered list of distinct 32-bit ids held in a row of CAPACITY cells. A command beat is
// taken, then an eval state compares the key against every cell and decides, and an apply
// state lets the cells shift; a move is done as a single rotation of the cells between its two
// positions. The response beat waits in an output register, so the next command can be taken
// with the apply and evaluated while that beat is still stalled; a command is held off during
// eval, and at apply while that register is still full and stalled.
// depends on ouil_pkg, ouil_cell and assert_macros.svh
`include "assert_macros.svh"

module ordered_unique_id_list
   import ouil_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_cmd,
   input  logic [ID_W-1:0]   req_card_id,
   input  logic [POS_W-1:0]  req_first_position,
   input  logic [POS_W-1:0]  req_second_position,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [POS_W-1:0]  rsp_found_index,
   output logic [CNT_W-1:0]  rsp_entry_count
);

   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(CAPACITY - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_APPLY
   } state_type;

   state_type state_ff;

   logic [2:0]       cmd_ff;
   logic [ID_W-1:0]  id_ff;
   logic [POS_W-1:0] p1_ff;
   logic [POS_W-1:0] p2_ff;

   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_next_ff;
   logic [LEN_W-1:0] len_next_in;
   cell_ctl_type     ctl_ff;
   cell_ctl_type     ctl_in;
   logic [2:0]       status_ff;
   logic [2:0]       status_in;
   logic [POS_W-1:0] found_ff;
   logic [POS_W-1:0] found_in;

   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff;
   logic [POS_W-1:0] rsp_found_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   logic [ID_W-1:0]  cell_entry [CAPACITY];
   logic [CAPACITY-1:0] cell_match;
   cell_ctl_type     cell_ctl;

   logic             apply_go;
   logic             req_accept;
   logic             hit;
   logic [POS_W-1:0] hit_pos;
   logic [ID_W-1:0]  moved;
   logic [CNT_W-1:0] len_wide;
   logic [CNT_W-1:0] ins_pos;

   assign apply_go   = (state_ff == ST_APPLY) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = !((state_ff == ST_IDLE) || apply_go);
   assign req_accept = req_valid && !req_stall;

   assign cell_ctl = apply_go ? ctl_ff
                              : cell_ctl_type'{op: CELL_HOLD, lo: '0, hi: '0, data: '0};

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ID_W-1:0] left_w;
      logic [ID_W-1:0] right_w;
      if (g == 0) begin : g_first
         assign left_w = cell_ctl.data;
      end else begin : g_mid_l
         assign left_w = cell_entry[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_w = cell_ctl.data;
      end else begin : g_mid_r
         assign right_w = cell_entry[g+1];
      end
      ouil_cell #(.INDEX(g)) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .key         (id_ff),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry       (cell_entry[g]),
         .match       (cell_match[g])
      );
   end

   // key search and entry pick-up across the row
   always_comb begin
      hit     = 1'b0;
      hit_pos = '0;
      moved   = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_match[i] && (CNT_W'(i) < CNT_W'(len_ff))) begin
            hit     = 1'b1;
            hit_pos = hit_pos | POS_W'(i);
         end
         if (POS_W'(i) == p1_ff) begin
            moved = moved | cell_entry[i];
         end
      end
   end

   assign len_wide = CNT_W'(len_ff);
   assign ins_pos  = ({1'b0, p1_ff} > len_wide) ? len_wide : {1'b0, p1_ff};

   always_comb begin
      ctl_in      = '{op: CELL_HOLD, lo: '0, hi: LAST_POS, data: id_ff};
      status_in   = STAT_OK;
      found_in    = '0;
      len_next_in = len_ff;
      unique case (cmd_ff)
         CMD_APPEND, CMD_INSERT: begin
            if (hit) begin
               status_in = STAT_DUP;
            end else if (len_wide >= CNT_W'(CAPACITY)) begin
               status_in = STAT_FULL;
            end else begin
               ctl_in.op   = CELL_SHIFT_UP;
               ctl_in.lo   = (cmd_ff == CMD_APPEND) ? POS_W'(len_ff) : POS_W'(ins_pos);
               len_next_in = len_ff + 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (hit) begin
               ctl_in.op   = CELL_SHIFT_DOWN;
               ctl_in.lo   = hit_pos;
               len_next_in = len_ff - 1'b1;
            end else begin
               status_in = STAT_NOT_FOUND;
            end
         end
         CMD_MOVE: begin
            ctl_in.data = moved;
            if ({1'b0, p1_ff} >= len_wide || {1'b0, p2_ff} >= len_wide) begin
               status_in = STAT_RANGE;
            end else if (p2_ff > p1_ff) begin
               ctl_in.op = CELL_SHIFT_DOWN;
               ctl_in.lo = p1_ff;
               ctl_in.hi = p2_ff - 1'b1;
            end else if (p2_ff < p1_ff) begin
               ctl_in.op = CELL_SHIFT_UP;
               ctl_in.lo = p2_ff;
               ctl_in.hi = p1_ff;
            end
         end
         CMD_LOOKUP: begin
            if (hit) begin
               found_in = hit_pos;
            end else begin
               status_in = STAT_NOT_FOUND;
            end
         end
         default: status_in = STAT_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (apply_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               if (apply_go) begin
                  len_ff        <= len_next_ff;
                  rsp_status_ff <= status_ff;
                  rsp_found_ff  <= found_ff;
                  rsp_count_ff  <= CNT_W'(len_next_ff);
                  state_ff      <= req_accept ? ST_EVAL : ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= req_cmd;
         id_ff  <= req_card_id;
         p1_ff  <= req_first_position;
         p2_ff  <= req_second_position;
      end
      if (state_ff == ST_EVAL) begin
         ctl_ff      <= ctl_in;
         status_ff   <= status_in;
         found_ff    <= found_in;
         len_next_ff <= len_next_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

   `ASSERT_ALWAYS(a_len_bound, clock, reset, CNT_W'(len_ff) <= CNT_W'(CAPACITY), "length above capacity")
   `ASSERT_NEXT(a_eval_to_apply, clock, reset, state_ff == ST_EVAL, state_ff == ST_APPLY, "eval not followed by apply")
   `ASSERT_NEXT(a_len_only_apply, clock, reset, !apply_go, $stable(len_ff), "length changed outside apply")
   `ASSERT_ALWAYS(a_rsp_from_apply, clock, reset, !$rose(rsp_valid_ff) || $past(apply_go), "response beat without apply")

endmodule

// ===== test/tb_ordered_unique_id_list.sv =====
// self-checking testbench for ordered_unique_id_list: a shadow list predicts every response beat
// needs ouil_pkg and the ordered_unique_id_list rtl with its ouil_cell and assert_macros.svh
module tb_ordered_unique_id_list
   import ouil_pkg::*;
();

   localparam int          CLK_PERIOD  = 10;
   localparam int          LIST_DEPTH  = 16;
   localparam int          POOL_SIZE   = 24;
   localparam int          HOLD_CYCLES = 400;
   localparam int          TAIL_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT = 200000;

   localparam logic [2:0] CMD_SPARE_5 = 3'd5;
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [2:0]       status;
      logic [POS_W-1:0] found;
      logic [CNT_W-1:0] count;
   } list_outcome_type;

   logic              clock               = 1'b0;
   logic              reset               = 1'b1;
   logic              req_valid           = 1'b0;
   logic              req_stall;
   logic [2:0]        req_cmd             = CMD_APPEND;
   logic [ID_W-1:0]   req_card_id         = '0;
   logic [POS_W-1:0]  req_first_position  = '0;
   logic [POS_W-1:0]  req_second_position = '0;
   logic              rsp_valid;
   logic              rsp_stall           = 1'b0;
   logic [2:0]        rsp_status;
   logic [POS_W-1:0]  rsp_found_index;
   logic [CNT_W-1:0]  rsp_entry_count;

   // shadow copy of the list
   logic [ID_W-1:0]   shadow_ids [LIST_DEPTH];
   int unsigned       shadow_len = 0;
   list_outcome_type  pending_outcomes [$];
   logic [ID_W-1:0]   id_pool [POOL_SIZE];

   int unsigned       error_count      = 0;
   int unsigned       cycle_count      = 0;
   bit                send_idle_on     = 1'b1;
   logic              rsp_idle_on      = 1'b1;
   logic              hold_toggle      = 1'b0;
   logic              hold_toggle_seen = 1'b0;
   int unsigned       hold_left        = 0;

   ordered_unique_id_list #(
      .CAPACITY(LIST_DEPTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_card_id         (req_card_id),
      .req_first_position  (req_first_position),
      .req_second_position (req_second_position),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_found_index     (rsp_found_index),
      .rsp_entry_count     (rsp_entry_count)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL ordered_unique_id_list");
      $finish;
   end

   function automatic int unsigned shadow_find(input logic [ID_W-1:0] id);
      for (int unsigned i = 0; i < shadow_len; i++) begin
         if (shadow_ids[i] == id) return i;
      end
      return shadow_len;
   endfunction

   function automatic void shadow_put(input int unsigned pos, input logic [ID_W-1:0] id);
      for (int unsigned i = shadow_len; i > pos; i--) begin
         shadow_ids[i] = shadow_ids[i-1];
      end
      shadow_ids[pos] = id;
      shadow_len++;
   endfunction

   function automatic void shadow_take(input int unsigned pos);
      for (int unsigned i = pos; i + 1 < shadow_len; i++) begin
         shadow_ids[i] = shadow_ids[i+1];
      end
      shadow_len--;
   endfunction

   // duplicate check comes before the capacity check
   function automatic logic [2:0] shadow_add(input logic [ID_W-1:0] id, input int unsigned pos);
      if (shadow_find(id) < shadow_len) return STAT_DUP;
      if (shadow_len >= LIST_DEPTH) return STAT_FULL;
      shadow_put((pos > shadow_len) ? shadow_len : pos, id);
      return STAT_OK;
   endfunction

   function automatic list_outcome_type track_command(input logic [2:0] cmd,
         input logic [ID_W-1:0] id, input logic [POS_W-1:0] p1, input logic [POS_W-1:0] p2);
      list_outcome_type res;
      int unsigned      at;
      logic [ID_W-1:0]  moved;
      res.status = STAT_OK;
      res.found  = '0;
      case (cmd)
         CMD_APPEND: res.status = shadow_add(id, shadow_len);
         CMD_INSERT: res.status = shadow_add(id, p1);
         CMD_REMOVE: begin
            at = shadow_find(id);
            if (at < shadow_len) shadow_take(at);
            else res.status = STAT_NOT_FOUND;
         end
         CMD_MOVE: begin
            if (p1 >= shadow_len || p2 >= shadow_len) begin
               res.status = STAT_RANGE;
            end else if (p1 != p2) begin
               moved = shadow_ids[p1];
               shadow_take(p1);
               shadow_put((p2 > p1) ? p2 - 1 : p2, moved);
            end
         end
         CMD_LOOKUP: begin
            at = shadow_find(id);
            if (at < shadow_len) res.found = POS_W'(at);
            else res.status = STAT_NOT_FOUND;
         end
         default: ;
      endcase
      res.count = CNT_W'(shadow_len);
      return res;
   endfunction

   task automatic send_beat(input logic [2:0] cmd, input logic [ID_W-1:0] id,
         input logic [POS_W-1:0] p1, input logic [POS_W-1:0] p2);
      int unsigned gap;
      gap = 0;
      if (send_idle_on) begin
         while ($urandom_range(99) < 31) gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_cmd             <= cmd;
      req_card_id         <= id;
      req_first_position  <= p1;
      req_second_position <= p2;
      do @(posedge clock); while (req_stall);
      pending_outcomes.insert(pending_outcomes.size(), track_command(cmd, id, p1, p2));
   endtask

   task automatic wait_for_outcomes();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   task automatic check_outcome();
      list_outcome_type want;
      if (pending_outcomes.size() == 0) begin
         $display("%0t: unexpected beat status=%0d found=%0d count=%0d", $time,
                  rsp_status, rsp_found_index, rsp_entry_count);
         error_count++;
      end else begin
         want = pending_outcomes.pop_front();
         if (rsp_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
            error_count++;
         end
         if (rsp_found_index !== want.found) begin
            $display("%0t: found_index expected %0d actual %0d", $time, want.found,
                     rsp_found_index);
            error_count++;
         end
         if (rsp_entry_count !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                     rsp_entry_count);
            error_count++;
         end
      end
   endtask

   // long receiver hold-off, started by toggling hold_toggle
   always @(posedge clock) begin
      hold_toggle_seen <= hold_toggle;
      if (hold_toggle != hold_toggle_seen) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_outcome();
         rsp_stall <= (hold_left != 0) || (rsp_idle_on && $urandom_range(99) < 31);
      end
   end

   function automatic logic [ID_W-1:0] pick_id(input bit from_list);
      if (from_list && shadow_len != 0 && $urandom_range(99) < 75)
         return shadow_ids[$urandom_range(shadow_len - 1)];
      if ($urandom_range(99) < 80) return id_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic logic [POS_W-1:0] pick_pos();
      if ($urandom_range(99) < 75) return POS_W'($urandom_range(LIST_DEPTH + 1));
      return POS_W'($urandom_range(255));
   endfunction

   function automatic logic [POS_W-1:0] pick_index();
      if (shadow_len != 0 && $urandom_range(99) < 70)
         return POS_W'($urandom_range(shadow_len - 1));
      return pick_pos();
   endfunction

   task automatic run_random(input int unsigned n_items, input int unsigned grow_pct);
      int unsigned      r;
      logic [2:0]       cmd;
      logic [ID_W-1:0]  id;
      logic [POS_W-1:0] p1;
      logic [POS_W-1:0] p2;
      for (int unsigned k = 0; k < n_items; k++) begin
         r = $urandom_range(99);
         if (r < 5) begin
            case ($urandom_range(2))
               0:       cmd = CMD_SPARE_5;
               1:       cmd = CMD_SPARE_6;
               default: cmd = CMD_SPARE_7;
            endcase
         end else if (r < 5 + grow_pct) begin
            cmd = $urandom_range(1) ? CMD_APPEND : CMD_INSERT;
         end else begin
            r = $urandom_range(9);
            cmd = (r < 4) ? CMD_REMOVE : (r < 7) ? CMD_MOVE : CMD_LOOKUP;
         end
         case (cmd)
            CMD_APPEND, CMD_INSERT: id = pick_id($urandom_range(99) < 15);
            CMD_REMOVE, CMD_LOOKUP: id = pick_id(1'b1);
            default:                id = $urandom;
         endcase
         p1 = (cmd == CMD_MOVE) ? pick_index() : (cmd == CMD_INSERT) ? pick_pos()
                                               : POS_W'($urandom_range(255));
         p2 = (cmd == CMD_MOVE) ? pick_index() : POS_W'($urandom_range(255));
         send_beat(cmd, id, p1, p2);
      end
   endtask

   task automatic test_directed_cases();
      send_beat(CMD_LOOKUP, 32'h0000_0000, 8'd0, 8'd0);
      send_beat(CMD_REMOVE, 32'h0000_0000, 8'd0, 8'd0);
      send_beat(CMD_MOVE, 32'h0000_0000, 8'd0, 8'd0);
      send_beat(CMD_SPARE_5, 32'hFFFF_FFFF, 8'd255, 8'd255);
      send_beat(CMD_SPARE_6, 32'h0000_0000, 8'd0, 8'd255);
      send_beat(CMD_SPARE_7, 32'h1234_5678, 8'd255, 8'd0);
      send_beat(CMD_APPEND, 32'h0000_0000, 8'd0, 8'd0);
      send_beat(CMD_APPEND, 32'hFFFF_FFFF, 8'd255, 8'd255);
      send_beat(CMD_APPEND, 32'h0000_0000, 8'd0, 8'd0);
      send_beat(CMD_INSERT, 32'hA5A5_A5A5, 8'd0, 8'd0);
      // insert past the tail is clamped
      send_beat(CMD_INSERT, 32'h5A5A_5A5A, 8'd255, 8'd0);
      send_beat(CMD_INSERT, 32'hFFFF_FFFF, 8'd1, 8'd0);
      send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 8'd0, 8'd0);
      send_beat(CMD_MOVE, 32'h0000_0000, 8'd0, 8'd3);
      send_beat(CMD_MOVE, 32'h0000_0000, 8'd3, 8'd0);
      send_beat(CMD_MOVE, 32'h0000_0000, 8'd1, 8'd1);
      send_beat(CMD_MOVE, 32'h0000_0000, 8'd2, 8'd255);
      send_beat(CMD_MOVE, 32'h0000_0000, 8'd4, 8'd0);
      send_beat(CMD_REMOVE, 32'h0000_0000, 8'd0, 8'd0);
      send_beat(CMD_REMOVE, 32'h1234_5678, 8'd0, 8'd0);
      send_beat(CMD_LOOKUP, 32'hA5A5_A5A5, 8'd0, 8'd0);
      send_beat(CMD_INSERT, 32'h0000_0000, 8'd3, 8'd0);
      wait_for_outcomes();
   endtask

   // long stretch with no idling on either side
   task automatic test_random_steady();
      send_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      run_random(150, 70);
      run_random(150, 20);
      wait_for_outcomes();
   endtask

   // grow, drain and balanced phases with both sides idling
   task automatic test_random_with_idling();
      send_idle_on = 1'b1;
      rsp_idle_on <= 1'b1;
      for (int unsigned ph = 0; ph < 10; ph++) begin
         run_random(100, (ph % 3 == 0) ? 70 : (ph % 3 == 1) ? 20 : 45);
         if (ph % 4 == 3) wait_for_outcomes();
      end
      wait_for_outcomes();
   endtask

   // receiver holds off while the sender keeps offering beats
   task automatic test_receiver_holdoff();
      send_idle_on = 1'b0;
      hold_toggle <= ~hold_toggle;
      run_random(80, 50);
      wait_for_outcomes();
   endtask

   task automatic test_random_tail();
      send_idle_on = 1'b1;
      rsp_idle_on <= 1'b1;
      run_random(200, 70);
      run_random(200, 30);
   endtask

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom;
      id_pool[0] = '0;
      id_pool[1] = '1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_steady();
      test_random_with_idling();
      test_receiver_holdoff();
      test_random_tail();
      wait_for_outcomes();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS ordered_unique_id_list");
      end else begin
         $display("FAIL ordered_unique_id_list");
      end
      $finish;
   end

endmodule
